/* design/mbps_pkg.sv */
package mbps_pkg;

    // Pattern slots that carry a byte and a care bit in the register file
    localparam int PATTERN_SLOTS = 16;
    localparam int SLOT_W = $clog2(PATTERN_SLOTS);
    localparam int PATTERN_MAX_DEFAULT = 16;

    localparam int LENGTH_W = 5;
    localparam int CARE_W = 16;
    localparam int LIMIT_W = 16;
    localparam int ADDR_W = 64;
    localparam int BYTE_W = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LIMIT = 3'd5;

    typedef struct packed {
        logic advance;
        logic clear;
    } mbps_cell_ctrl_t;

    typedef struct packed {
        logic found;
        logic [ADDR_W-1:0] match_address;
        logic scan_done;
    } mbps_result_t;

endpackage

/* design/mbps_cell.sv */
module mbps_cell #(
    parameter int CELL_INDEX = 0,
    parameter int LEN_W = 5
) (
    input  logic clk,
    input  logic rst_n,
    input  mbps_pkg::mbps_cell_ctrl_t ctrl,
    input  logic [mbps_pkg::BYTE_W-1:0] byte_in,
    input  logic [mbps_pkg::BYTE_W*mbps_pkg::PATTERN_SLOTS-1:0] pattern_bytes,
    input  logic [mbps_pkg::PATTERN_SLOTS-1:0] care_bits,
    input  logic [LEN_W-1:0] pattern_len,
    output logic [mbps_pkg::BYTE_W-1:0] byte_out,
    output logic cell_ok
);
    import mbps_pkg::*;

    localparam logic [LEN_W-1:0] K = LEN_W'(CELL_INDEX);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic in_use;
    logic [LEN_W-1:0] pos_full;
    logic [SLOT_W-1:0] slot;
    logic slot_exists;
    logic cares;
    logic [BYTE_W-1:0] want;

    // This cell checks its input byte, taken CELL_INDEX beats before the byte being
    // accepted, against pattern position len-1-CELL_INDEX and registers it for the next cell.
    always_comb
    begin
        in_use = K < pattern_len;
        pos_full = pattern_len - K - LEN_W'(1);
        slot = pos_full[SLOT_W-1:0];
        slot_exists = pos_full < LEN_W'(PATTERN_SLOTS);
        want = pattern_bytes[{slot, 3'b000} +: BYTE_W];
        cares = slot_exists && care_bits[slot];
        cell_ok = !in_use || !cares || (byte_in == want);
    end

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.advance)
        begin
            byte_next = ctrl.clear ? '0 : byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

/* design/mbps_out_queue.sv */
module mbps_out_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  mbps_pkg::mbps_result_t push_data,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output mbps_pkg::mbps_result_t out_data
);
    import mbps_pkg::*;

    logic head_valid_reg;
    logic head_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    mbps_result_t head_reg;
    mbps_result_t head_next;
    mbps_result_t skid_reg;
    mbps_result_t skid_next;
    logic drain;

    always_comb
    begin
        drain = !head_valid_reg || !out_stall;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        if (drain)
        begin
            if (skid_valid_reg)
            begin
                // advance the held beat; no push can arrive while the skid is full
                head_valid_next = 1'b1;
                head_next = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = push;
                head_next = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign full = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data = head_reg;

endmodule

/* design/masked_byte_pattern_scan.sv */
// A result beat enters the two-entry output queue at the edge that accepts its byte.
// Throughput: one byte per cycle while in_stall is low; the compare across the cell row
// and the address add finish in the accepting cycle, and the queue absorbs stalls.
// Bytes that cause no result (no match, not the last byte) produce no beat.
// Reset (rst_n low, asynchronous): configuration registers read zero, the window, fill
// count, offset and match count clear, the output queue empties; no clearing pass follows.
module masked_byte_pattern_scan #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [mbps_pkg::BYTE_W-1:0] data_byte,
    input  logic end_of_buffer,
    output logic out_valid,
    input  logic out_stall,
    output logic found,
    output logic [mbps_pkg::ADDR_W-1:0] match_address,
    output logic scan_done
);
    import mbps_pkg::*;

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);
    localparam int LEN_W = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

    // Configuration registers
    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [CARE_W-1:0] care_mask_reg;
    logic [LENGTH_W-1:0] pattern_length_reg;
    logic [ADDR_W-1:0] base_address_reg;
    logic [LIMIT_W-1:0] match_limit_reg;

    // Scan state outside the cell row
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;
    logic [ADDR_W-1:0] byte_offset_reg;
    logic [ADDR_W-1:0] byte_offset_next;
    logic [LIMIT_W-1:0] reported_reg;
    logic [LIMIT_W-1:0] reported_next;

    logic in_accept;
    logic queue_full;
    mbps_cell_ctrl_t cell_ctrl;
    logic [BYTE_W-1:0] byte_chain [0:PATTERN_MAX-1];
    logic [PATTERN_MAX-1:0] cell_ok;
    logic [BYTE_W*PATTERN_SLOTS-1:0] pattern_bytes;

    logic [LEN_W-1:0] len_ext;
    logic [LEN_W-1:0] len_clamp;
    logic [CNT_W-1:0] fill_after;
    logic filled;
    logic under_limit;
    logic hit;
    logic [ADDR_W-1:0] hit_address;
    mbps_result_t result;
    mbps_result_t queue_data;

    assign in_stall = queue_full;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes; an index past the register list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg <= '0;
            pattern_high_reg <= '0;
            care_mask_reg <= '0;
            pattern_length_reg <= '0;
            base_address_reg <= '0;
            match_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LOW: pattern_low_reg <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_CARE_MASK: care_mask_reg <= cfg_data[CARE_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LENGTH_W-1:0];
                REG_BASE_ADDRESS: base_address_reg <= cfg_data;
                REG_MATCH_LIMIT: match_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign pattern_bytes = {pattern_high_reg, pattern_low_reg};

    // Shift the row on every accepted beat; clear it behind the last byte
    assign cell_ctrl.advance = in_accept;
    assign cell_ctrl.clear = end_of_buffer;
    assign byte_chain[0] = data_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        if (k < PATTERN_MAX - 1)
        begin : g_link
            mbps_cell #(
                .CELL_INDEX(k),
                .LEN_W(LEN_W)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .ctrl(cell_ctrl),
                .byte_in(byte_chain[k]),
                .pattern_bytes(pattern_bytes),
                .care_bits(care_mask_reg),
                .pattern_len(len_clamp),
                .byte_out(byte_chain[k+1]),
                .cell_ok(cell_ok[k])
            );
        end
        else
        begin : g_tail
            // The oldest byte falls off the end of the row
            mbps_cell #(
                .CELL_INDEX(k),
                .LEN_W(LEN_W)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .ctrl(cell_ctrl),
                .byte_in(byte_chain[k]),
                .pattern_bytes(pattern_bytes),
                .care_bits(care_mask_reg),
                .pattern_len(len_clamp),
                .byte_out(),
                .cell_ok(cell_ok[k])
            );
        end
    end

    // Match decision for the byte being accepted
    always_comb
    begin
        len_ext = LEN_W'(pattern_length_reg);
        len_clamp = (len_ext > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_ext;
        fill_after = (fill_count_reg < CNT_W'(PATTERN_MAX)) ?
                     fill_count_reg + CNT_W'(1) : fill_count_reg;
        filled = LEN_W'(fill_after) >= len_clamp;
        under_limit = (match_limit_reg == '0) || (reported_reg < match_limit_reg);
        hit = (len_clamp != '0) && filled && under_limit && (&cell_ok);
        // Start address: base plus offset of this byte, back by len-1
        hit_address = base_address_reg + byte_offset_reg
                      - ADDR_W'(len_clamp) + ADDR_W'(1);
    end

    // Scan counters; drop everything after the last byte of a buffer
    always_comb
    begin
        fill_count_next = fill_count_reg;
        byte_offset_next = byte_offset_reg;
        reported_next = reported_reg;
        if (in_accept)
        begin
            if (end_of_buffer)
            begin
                fill_count_next = '0;
                byte_offset_next = '0;
                reported_next = '0;
            end
            else
            begin
                fill_count_next = fill_after;
                byte_offset_next = byte_offset_reg + ADDR_W'(1);
                if (hit && (reported_reg != {LIMIT_W{1'b1}}))
                begin
                    reported_next = reported_reg + LIMIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            byte_offset_reg <= '0;
            reported_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            byte_offset_reg <= byte_offset_next;
            reported_reg <= reported_next;
        end
    end

    always_comb
    begin
        result.found = hit;
        result.match_address = hit ? hit_address : '0;
        result.scan_done = end_of_buffer;
    end

    // Hold result beats so the input flows under output stall until the queue fills
    mbps_out_queue u_out_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(in_accept && (hit || end_of_buffer)),
        .push_data(result),
        .full(queue_full),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(queue_data)
    );

    assign found = queue_data.found;
    assign match_address = queue_data.match_address;
    assign scan_done = queue_data.scan_done;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_buffer) |=> (fill_count_reg == '0 && byte_offset_reg == '0
                                          && reported_reg == '0))
        else $error("scan state not cleared after last byte");

    a_last_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_buffer) |=> out_valid)
        else $error("last byte produced no result beat");

    a_stall_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(PATTERN_MAX))
        else $error("fill count past window depth");
`endif

endmodule

/* bench/masked_byte_pattern_scan_test.sv */
`timescale 1ns / 100ps

module masked_byte_pattern_scan_test;

    import mbps_pkg::*;

    localparam int PATTERN_MAX = PATTERN_MAX_DEFAULT;

    // Indexes past the register list; writes to them must leave the block untouched
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_BYTES = 106;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 3;
    localparam int END_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic { ROW_CONFIG, ROW_BYTE } row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0] value;
        logic [BYTE_W-1:0] data;
        logic last;
        bit typed;
        mbps_result_t result;
    } stim_row_t;

    // Block ports; every input starts at a known value
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [BYTE_W-1:0] data_byte = '0;
    logic end_of_buffer = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found;
    logic [ADDR_W-1:0] match_address;
    logic scan_done;

    // Predictor copy of the register file
    logic [63:0] cfg_pat_lo;
    logic [63:0] cfg_pat_hi;
    logic [CARE_W-1:0] cfg_care;
    logic [LENGTH_W-1:0] cfg_len;
    logic [ADDR_W-1:0] cfg_base;
    logic [LIMIT_W-1:0] cfg_limit;

    // Predictor copy of the scan state
    logic [BYTE_W-1:0] scan_window [0:PATTERN_MAX-1];
    int window_fill;
    logic [ADDR_W-1:0] scan_offset;
    logic [LIMIT_W-1:0] matches_reported;

    mbps_result_t pending_results [$];
    stim_row_t directed_rows [$];
    mbps_result_t monitor_expect;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    int fail_count = 0;
    int bytes_sent = 0;
    int buffers_closed = 0;
    int results_checked = 0;
    int matches_seen = 0;
    int settings_applied = 0;

    masked_byte_pattern_scan #(
        .PATTERN_MAX(PATTERN_MAX)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .end_of_buffer(end_of_buffer),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .match_address(match_address),
        .scan_done(scan_done)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Drop the window, fill count, offset and match count, as at a buffer end
    function automatic void clear_scan_state();
        int k;
        for (k = 0; k < PATTERN_MAX; k++)
        begin
            scan_window[k] = '0;
        end
        window_fill = 0;
        scan_offset = '0;
        matches_reported = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PATTERN_LOW:    cfg_pat_lo = val;
            REG_PATTERN_HIGH:   cfg_pat_hi = val;
            REG_CARE_MASK:      cfg_care = val[CARE_W-1:0];
            REG_PATTERN_LENGTH: cfg_len = val[LENGTH_W-1:0];
            REG_BASE_ADDRESS:   cfg_base = val;
            REG_MATCH_LIMIT:    cfg_limit = val[LIMIT_W-1:0];
            default:            ;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int pos);
        logic [127:0] packed_pattern;
        packed_pattern = {cfg_pat_hi, cfg_pat_lo};
        return packed_pattern[8*pos +: 8];
    endfunction

    function automatic int active_length();
        return (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
    endfunction

    // Shift one byte into the window and work out the beat it causes, if any
    function automatic void predict_scan(input logic [BYTE_W-1:0] d, input logic last,
                                         output bit has_result,
                                         output mbps_result_t res);
        int len;
        int j;
        int k;
        logic hit;
        len = active_length();
        for (k = PATTERN_MAX - 1; k > 0; k--)
        begin
            scan_window[k] = scan_window[k-1];
        end
        scan_window[0] = d;
        if (window_fill < PATTERN_MAX)
        begin
            window_fill++;
        end

        hit = 1'b0;
        if (len > 0 && window_fill >= len && (cfg_limit == 0 || matches_reported < cfg_limit))
        begin
            hit = 1'b1;
            // Slot j of the pattern lines up with the byte taken len-1-j beats ago;
            // slots past the care mask are wildcards
            for (j = 0; j < len; j++)
            begin
                if (j < PATTERN_SLOTS && cfg_care[j] && scan_window[len-1-j] != pattern_byte(j))
                begin
                    hit = 1'b0;
                end
            end
        end

        res.found = hit;
        res.match_address = '0;
        res.scan_done = last;
        if (hit)
        begin
            res.match_address = cfg_base + scan_offset - ADDR_W'(len - 1);
            if (matches_reported != {LIMIT_W{1'b1}})
            begin
                matches_reported++;
            end
        end
        scan_offset++;
        has_result = hit || last;
        if (last)
        begin
            clear_scan_state();
        end
    endfunction

    // Queue an expected beat behind the ones already waiting
    function automatic void expect_beat(input mbps_result_t res);
        pending_results.insert(pending_results.size(), res);
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic void append_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_config(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.kind = ROW_CONFIG;
        row.index = idx;
        row.value = val;
        row.data = '0;
        row.last = 1'b0;
        row.typed = 1'b0;
        row.result = '0;
        append_row(row);
    endfunction

    function automatic void add_byte(input logic [BYTE_W-1:0] d, input logic last);
        stim_row_t row;
        row.kind = ROW_BYTE;
        row.index = '0;
        row.value = '0;
        row.data = d;
        row.last = last;
        row.typed = 1'b0;
        row.result = '0;
        append_row(row);
    endfunction

    // Byte row whose result beat is written out by hand
    function automatic void add_checked(input logic [BYTE_W-1:0] d, input logic last,
                                        input logic f, input logic [ADDR_W-1:0] addr,
                                        input logic done);
        stim_row_t row;
        row.kind = ROW_BYTE;
        row.index = '0;
        row.value = '0;
        row.data = d;
        row.last = last;
        row.typed = 1'b1;
        row.result.found = f;
        row.result.match_address = addr;
        row.result.scan_done = done;
        append_row(row);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one byte beat, hold it until accepted, then record what it should cause.
    // Idle gaps carry junk payload with valid low.
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic last,
                             input bit typed, input mbps_result_t typed_result);
        bit has_result;
        mbps_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'($urandom_range(255));
            end_of_buffer <= 1'($urandom_range(1));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        end_of_buffer <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_scan(d, last, has_result, res);
        if (typed)
        begin
            expect_beat(typed_result);
        end
        else if (has_result)
        begin
            expect_beat(res);
        end
        bytes_sent++;
        if (last)
        begin
            buffers_closed++;
        end
    endtask

    // Drop valid, wait for every expected beat, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        apply_register(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Pick a fresh register setting, weighted toward the edges of each field
    task automatic randomize_config(input int phase);
        logic [LENGTH_W-1:0] len;
        logic [CARE_W-1:0] care;
        logic [ADDR_W-1:0] base;
        logic [LIMIT_W-1:0] limit;
        int pick;

        pick = $urandom_range(99);
        if (phase == 1)
            len = 5'd16;
        else if (pick < 5)
            len = 5'd0;
        else if (pick < 12)
            len = 5'($urandom_range(17, 31));
        else if (pick < 25)
            len = 5'd16;
        else if (pick < 40)
            len = 5'd1;
        else
            len = 5'($urandom_range(2, 15));

        pick = $urandom_range(99);
        if (phase == 1 || pick < 25)
            care = 16'hFFFF;
        else if (pick < 35)
            care = 16'h0000;
        else
            care = 16'($urandom_range(65535));

        pick = $urandom_range(99);
        if (phase == 1 || pick < 15)
            base = {ADDR_W{1'b1}};
        else if (pick < 25)
            base = '0;
        else if (pick < 40)
            base = 64'hFFFF_FFFF_FFFF_FFF0;
        else
            base = {$urandom, $urandom};

        pick = $urandom_range(99);
        if (pick < 50)
            limit = '0;
        else if (pick < 65)
            limit = 16'd1;
        else if (pick < 80)
            limit = 16'($urandom_range(2, 4));
        else if (pick < 90)
            limit = 16'hFFFF;
        else
            limit = 16'($urandom_range(65535));

        write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
        write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
        write_reg(REG_CARE_MASK, 64'(care));
        write_reg(REG_PATTERN_LENGTH, 64'(len));
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_MATCH_LIMIT, 64'(limit));
        if ($urandom_range(3) == 0)
        begin
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
        end
        settings_applied++;
    endtask

    // Build one buffer: random bytes biased toward pattern values, with planted
    // copies of the pattern (some with one flipped bit), then stream it.
    // With close clear, the buffer is left open across the next setting.
    task automatic send_buffer(input int n, input bit close);
        logic [BYTE_W-1:0] scan_bytes [0:63];
        int len;
        int i;
        int j;
        int s;
        int copies;
        len = active_length();
        for (i = 0; i < n; i++)
        begin
            if (len > 0 && $urandom_range(2) == 0)
                scan_bytes[i] = pattern_byte($urandom_range(len - 1));
            else
                scan_bytes[i] = 8'($urandom_range(255));
        end
        if (len > 0 && len <= n && $urandom_range(99) >= 15)
        begin
            copies = $urandom_range(1, 3);
            repeat (copies)
            begin
                s = int'($urandom_range(n - len));
                for (j = 0; j < len; j++)
                begin
                    scan_bytes[s+j] = cfg_care[j] ? pattern_byte(j) : 8'($urandom_range(255));
                end
                if ($urandom_range(4) == 0)
                begin
                    scan_bytes[s + $urandom_range(len - 1)] ^= 8'(8'h01 << $urandom_range(7));
                end
            end
        end
        for (i = 0; i < n; i++)
        begin
            send_byte(scan_bytes[i], close && (i == n - 1), 1'b0, '0);
        end
    endtask

    // Record a failure; print only the first few
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall, plus a long hold-off on request to fill the block
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare every accepted beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("unexpected result beat found=%0b addr=%h done=%0b",
                                       found, match_address, scan_done));
            end
            else
            begin
                monitor_expect = pending_results.pop_front();
                results_checked++;
                if (found)
                begin
                    matches_seen++;
                end
                if (found !== monitor_expect.found
                    || match_address !== monitor_expect.match_address
                    || scan_done !== monitor_expect.scan_done)
                begin
                    note_failure({
                        $sformatf("mismatch: expected found=%0b addr=%h done=%0b,",
                                  monitor_expect.found, monitor_expect.match_address,
                                  monitor_expect.scan_done),
                        $sformatf(" got found=%0b addr=%h done=%0b",
                                  found, match_address, scan_done)});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves a beat for too long
    // ------------------------------------------------------------------
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        int phase;
        int phase_bytes;
        int n;
        bit close;

        cfg_pat_lo = '0;
        cfg_pat_hi = '0;
        cfg_care = '0;
        cfg_len = '0;
        cfg_base = '0;
        cfg_limit = '0;
        clear_scan_state();

        // Hold reset low, then release it on an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length after reset: nothing matches, but each buffer end still
        // gives a done beat
        add_checked(8'h00, 1'b1, 1'b0, '0, 1'b1);
        add_checked(8'hFF, 1'b1, 1'b0, '0, 1'b1);
        add_byte(8'h5A, 1'b0);
        add_checked(8'hA5, 1'b1, 1'b0, '0, 1'b1);

        // One wildcard byte: every byte matches at its own offset
        add_config(REG_PATTERN_LENGTH, 64'd1);
        add_config(REG_CARE_MASK, 64'h0);
        add_checked(8'h00, 1'b0, 1'b1, 64'd0, 1'b0);
        add_checked(8'hFF, 1'b1, 1'b1, 64'd1, 1'b1);

        // Top of the address space
        add_config(REG_BASE_ADDRESS, {ADDR_W{1'b1}});
        add_checked(8'h3C, 1'b1, 1'b1, {ADDR_W{1'b1}}, 1'b1);

        // Ten bytes spanning both pattern words, slot 3 a wildcard, base near wrap
        add_config(REG_PATTERN_LOW, 64'h8877_6655_4433_2211);
        add_config(REG_PATTERN_HIGH, 64'h0000_0000_0000_AA99);
        add_config(REG_CARE_MASK, 64'h03F7);
        add_config(REG_PATTERN_LENGTH, 64'd10);
        add_config(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFE);
        add_byte(8'h11, 1'b0);
        add_byte(8'h22, 1'b0);
        add_byte(8'h33, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'h66, 1'b0);
        add_byte(8'h77, 1'b0);
        add_byte(8'h88, 1'b0);
        add_byte(8'h99, 1'b0);
        add_byte(8'hAA, 1'b1);

        // Limit of one: the second match is swallowed, the end beat is bare
        add_config(REG_PATTERN_LENGTH, 64'd1);
        add_config(REG_CARE_MASK, 64'h0);
        add_config(REG_MATCH_LIMIT, 64'd1);
        add_config(REG_BASE_ADDRESS, 64'h100);
        add_checked(8'h01, 1'b0, 1'b1, 64'h100, 1'b0);
        add_byte(8'h02, 1'b0);
        add_checked(8'h03, 1'b1, 1'b0, '0, 1'b1);
        add_config(REG_MATCH_LIMIT, 64'hFFFF);

        // Oversized length clamps to the window; a short buffer never fills it
        add_config(REG_PATTERN_LENGTH, 64'd31);
        add_byte(8'hC3, 1'b0);
        add_byte(8'h3C, 1'b0);
        add_byte(8'h81, 1'b1);

        // Writes past the register list are dropped
        add_config(REG_SPARE_LO, {CFG_DATA_W{1'b1}});
        add_config(REG_SPARE_HI, {CFG_DATA_W{1'b1}});
        add_checked(8'h00, 1'b1, 1'b0, '0, 1'b1);

        for (r = 0; r < directed_rows.size(); r++)
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
            begin
                wait_drained();
                write_reg(directed_rows[r].index, directed_rows[r].value);
            end
            else
            begin
                send_byte(directed_rows[r].data, directed_rows[r].last,
                          directed_rows[r].typed, directed_rows[r].result);
            end
        end

        // Random phases: new setting each time, cycling through the idle mixes
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (phase == PRESSURE_PHASE)
            begin
                // Every byte matches, so a held-off receiver backs the block up
                write_reg(REG_PATTERN_LENGTH, 64'd1);
                write_reg(REG_CARE_MASK, 64'h0);
                write_reg(REG_MATCH_LIMIT, 64'h0);
                settings_applied++;
                hold_requests <= hold_requests + 1;
            end
            else
            begin
                randomize_config(phase);
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 24);
                // Trim the last buffer so every phase streams the same byte count
                if (n > PHASE_BYTES - phase_bytes)
                begin
                    n = PHASE_BYTES - phase_bytes;
                end
                close = (phase_bytes + n < PHASE_BYTES) || ($urandom_range(3) != 0);
                send_buffer(n, close);
                phase_bytes += n;
            end
        end

        // Drain everything, then keep watching for stray beats
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (END_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
        end

        $write("Scanned %0d bytes in %0d closed buffers under %0d register settings; ",
               bytes_sent, buffers_closed, settings_applied);
        $display("%0d result beats checked, %0d matches.", results_checked, matches_seen);
        $write("Exercised zero, clamped and full-length patterns, wildcards, limits, ");
        $display("address wrap, stalls and a %0d-cycle hold-off; %0d failures.",
                 HOLD_CYCLES, fail_count);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
